/* rtl/line_snap_point_solver_assert.svh */
// Assertion macros shared by the line snap point solver RTL.
`ifndef LINE_SNAP_POINT_SOLVER_ASSERT_SVH
`define LINE_SNAP_POINT_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("line snap point solver: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("line snap point solver: next-cycle implication failed");

`endif

/* rtl/lss_pkg.sv */
// Types, constants and helper functions shared by the line snap point solver.
package lss_pkg;

  localparam int FRAC_BITS = 8;
  localparam int SNAP_T    = 5 << FRAC_BITS;
  localparam int SNAP_T2   = SNAP_T * SNAP_T;
  localparam int LIM_AXIS  = SNAP_T - 1;
  // Largest cross product magnitude whose square stays below five times SNAP_T2.
  localparam int LIM_ISO   = 2862;
  localparam int RECIP5    = 13108;
  localparam int RECIP5_SH = 16;
  localparam int CR_W      = 13;
  localparam int SQ_W      = 24;
  localparam int SQ5_W     = 27;
  localparam int EX_W      = 12;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_AXIS = 2'd1;
  localparam logic [1:0] MODE_ISO  = 2'd2;

  typedef enum logic [1:0] {
    DIR_H      = 2'd0,
    DIR_V      = 2'd1,
    DIR_ISO_UP = 2'd2,
    DIR_ISO_DN = 2'd3
  } dir_e;

  typedef struct packed {
    logic                   valid;
    dir_e                   dir;
    logic signed [CR_W-1:0] cr;
    logic [SQ_W-1:0]        sq;
  } guide_t;

  typedef struct packed {
    logic                   v0;
    logic                   v1;
    logic                   par;
    logic                   drop0;
    logic                   near;
    logic signed [EX_W-1:0] ex;
    logic signed [EX_W-1:0] ey;
  } cross_t;

  function automatic logic signed [2:0] dir_dx(input dir_e d);
    logic signed [2:0] r;
    case (d)
      DIR_H:      r = 3'sd1;
      DIR_V:      r = 3'sd0;
      DIR_ISO_UP: r = 3'sd2;
      DIR_ISO_DN: r = 3'sd2;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] dir_dy(input dir_e d);
    logic signed [2:0] r;
    case (d)
      DIR_H:      r = 3'sd0;
      DIR_V:      r = 3'sd1;
      DIR_ISO_UP: r = 3'sd1;
      DIR_ISO_DN: r = -3'sd1;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic dir_iso(input dir_e d);
    return (d == DIR_ISO_UP) || (d == DIR_ISO_DN);
  endfunction

  // Squared distance term scaled by the squared length of the other direction.
  function automatic logic [SQ5_W-1:0] sq_scale(input logic [SQ_W-1:0] sq, input logic by5);
    logic [SQ5_W-1:0] s;
    s = SQ5_W'(sq);
    return by5 ? (s << 2) + s : s;
  endfunction

endpackage

/* rtl/lss_guide.sv */
// Three-stage search for the nearest guide line through one neighbour point.
module lss_guide #(
  parameter int W = 32
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic                 on_i,
  input  logic                 iso_i,
  input  logic signed [W-1:0]  cur_x_i,
  input  logic signed [W-1:0]  cur_y_i,
  input  logic signed [W-1:0]  ref_x_i,
  input  logic signed [W-1:0]  ref_y_i,
  output logic signed [W-1:0]  ref_x_o,
  output logic signed [W-1:0]  ref_y_o,
  output lss_pkg::guide_t      guide_o
);
  import lss_pkg::*;

  localparam int CW = W + 3;
  localparam logic signed [CW-1:0] LIM_A = CW'(LIM_AXIS);
  localparam logic signed [CW-1:0] LIM_I = CW'(LIM_ISO);

  logic signed [W:0]      dx, dy;
  logic signed [CW-1:0]   cr_full [4];
  logic [3:0]             win_d;

  logic signed [CR_W-1:0] cr1_q [4];
  logic [3:0]             win1_q;
  logic signed [W-1:0]    rx1_q, ry1_q;

  logic signed [CR_W-1:0] cr2_q [4];
  logic [SQ_W-1:0]        sq2_q [4];
  logic [3:0]             win2_q;
  logic signed [W-1:0]    rx2_q, ry2_q;

  guide_t                 guide_d, guide_q;
  logic signed [W-1:0]    rx3_q, ry3_q;

  // Stage one: cross products against the four directions and the distance test.
  always_comb begin
    dx = (W+1)'(cur_x_i) - (W+1)'(ref_x_i);
    dy = (W+1)'(cur_y_i) - (W+1)'(ref_y_i);
    cr_full[0] = CW'(dy);
    cr_full[1] = -CW'(dx);
    cr_full[2] = (CW'(dy) <<< 1) - CW'(dx);
    cr_full[3] = (CW'(dy) <<< 1) + CW'(dx);
    win_d[0] = on_i && (cr_full[0] <= LIM_A) && (cr_full[0] >= -LIM_A);
    win_d[1] = on_i && (cr_full[1] <= LIM_A) && (cr_full[1] >= -LIM_A);
    win_d[2] = on_i && iso_i && (cr_full[2] <= LIM_I) && (cr_full[2] >= -LIM_I);
    win_d[3] = on_i && iso_i && (cr_full[3] <= LIM_I) && (cr_full[3] >= -LIM_I);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < 4; k++) begin
        cr1_q[k] <= cr_full[k][CR_W-1:0];
      end
      win1_q <= win_d;
      rx1_q  <= ref_x_i;
      ry1_q  <= ref_y_i;
    end
  end

  // Stage two: squared cross products, formed at the full square width.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < 4; k++) begin
        cr2_q[k] <= cr1_q[k];
        sq2_q[k] <= $unsigned(SQ_W'(cr1_q[k]) * SQ_W'(cr1_q[k]));
      end
      win2_q <= win1_q;
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
    end
  end

  // Stage three: pick the nearest direction, the earlier one winning a tie.
  always_comb begin
    guide_d       = '0;
    guide_d.dir   = DIR_H;
    for (int k = 0; k < 4; k++) begin
      if (win2_q[k] && (!guide_d.valid ||
          sq_scale(sq2_q[k], dir_iso(guide_d.dir)) <
          sq_scale(guide_d.sq, dir_iso(dir_e'(2'(k)))))) begin
        guide_d.valid = 1'b1;
        guide_d.dir   = dir_e'(2'(k));
        guide_d.cr    = cr2_q[k];
        guide_d.sq    = sq2_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      guide_q <= guide_d;
      rx3_q   <= rx2_q;
      ry3_q   <= ry2_q;
    end
  end

  assign guide_o = guide_q;
  assign ref_x_o = rx3_q;
  assign ref_y_o = ry3_q;

endmodule

/* rtl/lss_proj.sv */
// Two-stage projection of the point onto one kept guide line.
module lss_proj #(
  parameter int W = 32
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  lss_pkg::guide_t      guide_i,
  input  logic signed [W-1:0]  cur_x_i,
  input  logic signed [W-1:0]  cur_y_i,
  output logic signed [W-1:0]  proj_x_o,
  output logic signed [W-1:0]  proj_y_o
);
  import lss_pkg::*;

  localparam int VW = CR_W + 2;
  localparam int PW = 32;

  logic signed [VW-1:0] vx, vy, tx_d, ty_d, tx_q, ty_q;
  logic signed [W-1:0]  cx_q, cy_q;
  logic signed [W:0]    rx, ry;
  logic signed [W-1:0]  px_q, py_q;

  // Rounded division by five, halves cannot occur.
  function automatic logic signed [VW-1:0] div5r(input logic signed [VW-1:0] v);
    logic [VW-1:0] m;
    logic [PW-1:0] p;
    logic [VW-1:0] q;
    m = v[VW-1] ? VW'(0) - $unsigned(v) : $unsigned(v);
    p = (PW'(m) + PW'(2)) * PW'(RECIP5);
    q = VW'(p >> RECIP5_SH);
    return v[VW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [W:0] r);
    if (r[W] != r[W-1]) begin
      return r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r[W-1:0];
  endfunction

  // The projection is the point moved back along the normal by cr over the length.
  always_comb begin
    vx = '0;
    vy = '0;
    case (guide_i.dir)
      DIR_H:      vy = VW'(guide_i.cr);
      DIR_V:      vx = -VW'(guide_i.cr);
      DIR_ISO_UP: begin
        vx = -VW'(guide_i.cr);
        vy = VW'(guide_i.cr) <<< 1;
      end
      DIR_ISO_DN: begin
        vx = VW'(guide_i.cr);
        vy = VW'(guide_i.cr) <<< 1;
      end
      default: vx = '0;
    endcase
    tx_d = dir_iso(guide_i.dir) ? div5r(vx) : vx;
    ty_d = dir_iso(guide_i.dir) ? div5r(vy) : vy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
      cx_q <= cur_x_i;
      cy_q <= cur_y_i;
    end
  end

  assign rx = (W+1)'(cx_q) - (W+1)'(tx_q);
  assign ry = (W+1)'(cy_q) - (W+1)'(ty_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      px_q <= sat(rx);
      py_q <= sat(ry);
    end
  end

  assign proj_x_o = px_q;
  assign proj_y_o = py_q;

endmodule

/* rtl/lss_cross.sv */
// Three-stage intersection of the two guide lines and the line drop decision.
module lss_cross #(
  parameter int W = 32
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  lss_pkg::guide_t      g0_i,
  input  lss_pkg::guide_t      g1_i,
  input  logic signed [W-1:0]  p0_x_i,
  input  logic signed [W-1:0]  p0_y_i,
  input  logic signed [W-1:0]  p1_x_i,
  input  logic signed [W-1:0]  p1_y_i,
  input  logic signed [W-1:0]  cur_x_i,
  input  logic signed [W-1:0]  cur_y_i,
  output lss_pkg::cross_t      xr_o,
  output logic signed [W-1:0]  ix_o,
  output logic signed [W-1:0]  iy_o
);
  import lss_pkg::*;

  localparam int NW0 = W + 3;
  localparam int NW  = W + 5;
  localparam int IW  = W + 6;
  localparam logic signed [IW:0] T_LIM = (IW+1)'(SNAP_T);

  logic signed [2:0]     d0x, d0y, d1x, d1y, mx_d, my_d;
  logic signed [5:0]     den, adn;
  logic signed [W:0]     wx, wy;
  logic signed [NW0-1:0] t1, t2, num_d;
  logic [1:0]            sh_d;

  logic signed [NW0-1:0] num_q;
  logic signed [2:0]     mx_q, my_q;
  logic [1:0]            sh_q;
  logic                  v0_4q, v1_4q, par_4q, drop0_4q;
  logic signed [W-1:0]   p0x_q, p0y_q;

  logic signed [IW-1:0]  ix_q, iy_q;
  logic                  v0_5q, v1_5q, par_5q, drop0_5q;

  logic signed [IW:0]    ex, ey;
  cross_t                xr_d, xr_q;
  logic signed [W-1:0]   ixs_q, iys_q;

  function automatic logic signed [NW-1:0] scale_round(input logic signed [NW0-1:0] n,
                                                       input logic signed [2:0] m,
                                                       input logic [1:0] sh);
    logic signed [NW-1:0] am;
    logic signed [NW-1:0] a;
    logic signed [NW-1:0] rnd;
    am = (m == 3'sd2 || m == -3'sd2) ? (NW'(n) <<< 1) :
         (m == 3'sd1 || m == -3'sd1) ? NW'(n) : '0;
    a  = (m < 0) ? -am : am;
    // Round half away from zero on the shift by the power of two.
    rnd = (sh == 2'd2) ? (a < 0 ? NW'(1) : NW'(2)) :
          (sh == 2'd1) ? (a < 0 ? NW'(0) : NW'(1)) : NW'(0);
    return (a + rnd) >>> sh;
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [IW-1:0] r);
    if (!(&r[IW-1:W-1] || ~|r[IW-1:W-1])) begin
      return r[IW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r[W-1:0];
  endfunction

  // Stage four: determinant, numerator and which line is farther.
  always_comb begin
    d0x = dir_dx(g0_i.dir);
    d0y = dir_dy(g0_i.dir);
    d1x = dir_dx(g1_i.dir);
    d1y = dir_dy(g1_i.dir);
    den = 6'(d0x) * 6'(d1y) - 6'(d0y) * 6'(d1x);
    adn = (den < 0) ? -den : den;
    sh_d = (adn == 6'sd4) ? 2'd2 : (adn == 6'sd2) ? 2'd1 : 2'd0;
    mx_d = (den < 0) ? -d0x : d0x;
    my_d = (den < 0) ? -d0y : d0y;
    wx = (W+1)'(p1_x_i) - (W+1)'(p0_x_i);
    wy = (W+1)'(p1_y_i) - (W+1)'(p0_y_i);
    t1 = (d1y == 3'sd1) ? NW0'(wx) : (d1y == -3'sd1) ? -NW0'(wx) : '0;
    t2 = (d1x == 3'sd2) ? (NW0'(wy) <<< 1) : (d1x == 3'sd1) ? NW0'(wy) : '0;
    num_d = t1 - t2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_q    <= num_d;
      mx_q     <= mx_d;
      my_q     <= my_d;
      sh_q     <= sh_d;
      par_4q   <= (den == 6'sd0);
      drop0_4q <= sq_scale(g0_i.sq, dir_iso(g1_i.dir)) > sq_scale(g1_i.sq, dir_iso(g0_i.dir));
      v0_4q    <= g0_i.valid;
      v1_4q    <= g1_i.valid;
      p0x_q    <= p0_x_i;
      p0y_q    <= p0_y_i;
    end
  end

  // Stage five: crossing point.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ix_q     <= IW'(p0x_q) + IW'(scale_round(num_q, mx_q, sh_q));
      iy_q     <= IW'(p0y_q) + IW'(scale_round(num_q, my_q, sh_q));
      v0_5q    <= v0_4q;
      v1_5q    <= v1_4q;
      par_5q   <= par_4q;
      drop0_5q <= drop0_4q;
    end
  end

  // Stage six: offset of the crossing from the point and the box test.
  always_comb begin
    ex = (IW+1)'(ix_q) - (IW+1)'(cur_x_i);
    ey = (IW+1)'(iy_q) - (IW+1)'(cur_y_i);
    xr_d.v0    = v0_5q;
    xr_d.v1    = v1_5q;
    xr_d.par   = par_5q;
    xr_d.drop0 = drop0_5q;
    xr_d.near  = (ex < T_LIM) && (ex > -T_LIM) && (ey < T_LIM) && (ey > -T_LIM);
    xr_d.ex    = ex[EX_W-1:0];
    xr_d.ey    = ey[EX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      xr_q  <= xr_d;
      ixs_q <= sat(ix_q);
      iys_q <= sat(iy_q);
    end
  end

  assign xr_o = xr_q;
  assign ix_o = ixs_q;
  assign iy_o = iys_q;

endmodule

/* rtl/line_snap_point_solver.sv */
// Line snap point solver: a seven-stage pipeline that snaps a Q(W-8).8 point onto
// horizontal, vertical and, in isometric mode, 2:1 diagonal guide lines through its
// previous and next neighbours. It takes one transaction per clock while the input is not
// stalled; the stages fall into direction search, crossing arithmetic and final choice.
// Every stage holds its own valid bit and advances whenever it is empty or the stage
// after it advances, so bubbles are squeezed out and a stall on the output reaches the
// input only once every stage is full. The snap mode register is sampled as a
// transaction enters and must be written only while the pipeline is empty.
`include "line_snap_point_solver_assert.svh"

module line_snap_point_solver #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          snap_mode_we_i,
  input  logic [1:0]                    snap_mode_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] cur_x_i,
  input  logic signed [COORD_WIDTH-1:0] cur_y_i,
  input  logic                          has_prev_i,
  input  logic signed [COORD_WIDTH-1:0] prev_x_i,
  input  logic signed [COORD_WIDTH-1:0] prev_y_i,
  input  logic                          has_next_i,
  input  logic signed [COORD_WIDTH-1:0] next_x_i,
  input  logic signed [COORD_WIDTH-1:0] next_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] snapped_x_o,
  output logic signed [COORD_WIDTH-1:0] snapped_y_o
);
  import lss_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int NSTAGE = 7;
  localparam int SSW    = 2 * EX_W + 1;

  logic [1:0]          mode_q;
  logic                on, iso;
  logic [NSTAGE:1]     v_q, en;

  logic signed [W-1:0] cur_x_q [1:6];
  logic signed [W-1:0] cur_y_q [1:6];

  guide_t              g0, g1;
  logic signed [W-1:0] p0x, p0y, p1x, p1y;
  cross_t              xr;
  logic signed [W-1:0] ix, iy;
  logic signed [W-1:0] pr0x, pr0y, pr1x, pr1y;
  logic signed [W-1:0] pr0x_q, pr0y_q, pr1x_q, pr1y_q;

  logic [SSW-1:0]      dist2;
  logic                hit, keep0;
  logic signed [W-1:0] snap_x_d, snap_y_d, snap_x_q, snap_y_q;

  // Mode register; a value of three behaves as axis aligned.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
    end else if (snap_mode_we_i) begin
      mode_q <= snap_mode_i;
    end
  end

  assign on  = (mode_q != MODE_OFF);
  assign iso = (mode_q == MODE_ISO);

  // A stage loads when it is empty or when the stage after it is loading.
  always_comb begin
    en[NSTAGE] = !v_q[NSTAGE] || !out_stall_i;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // The point itself travels alongside the work as far as the final choice.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cur_x_q[1] <= cur_x_i;
      cur_y_q[1] <= cur_y_i;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        cur_x_q[k] <= cur_x_q[k-1];
        cur_y_q[k] <= cur_y_q[k-1];
      end
    end
  end

  // Stages one to three: nearest guide line through each neighbour.
  lss_guide #(.W(W)) u_guide_prev (
    .clk_i   (clk_i),
    .en_i    (en[3:1]),
    .on_i    (on && has_prev_i),
    .iso_i   (iso),
    .cur_x_i (cur_x_i),
    .cur_y_i (cur_y_i),
    .ref_x_i (prev_x_i),
    .ref_y_i (prev_y_i),
    .ref_x_o (p0x),
    .ref_y_o (p0y),
    .guide_o (g0)
  );

  lss_guide #(.W(W)) u_guide_next (
    .clk_i   (clk_i),
    .en_i    (en[3:1]),
    .on_i    (on && has_next_i),
    .iso_i   (iso),
    .cur_x_i (cur_x_i),
    .cur_y_i (cur_y_i),
    .ref_x_i (next_x_i),
    .ref_y_i (next_y_i),
    .ref_x_o (p1x),
    .ref_y_o (p1y),
    .guide_o (g1)
  );

  // Stages four to six: crossing of the two lines.
  lss_cross #(.W(W)) u_cross (
    .clk_i   (clk_i),
    .en_i    (en[6:4]),
    .g0_i    (g0),
    .g1_i    (g1),
    .p0_x_i  (p0x),
    .p0_y_i  (p0y),
    .p1_x_i  (p1x),
    .p1_y_i  (p1y),
    .cur_x_i (cur_x_q[5]),
    .cur_y_i (cur_y_q[5]),
    .xr_o    (xr),
    .ix_o    (ix),
    .iy_o    (iy)
  );

  // Stages four and five: projection onto each line on its own.
  lss_proj #(.W(W)) u_proj_prev (
    .clk_i    (clk_i),
    .en_i     (en[5:4]),
    .guide_i  (g0),
    .cur_x_i  (cur_x_q[3]),
    .cur_y_i  (cur_y_q[3]),
    .proj_x_o (pr0x),
    .proj_y_o (pr0y)
  );

  lss_proj #(.W(W)) u_proj_next (
    .clk_i    (clk_i),
    .en_i     (en[5:4]),
    .guide_i  (g1),
    .cur_x_i  (cur_x_q[3]),
    .cur_y_i  (cur_y_q[3]),
    .proj_x_o (pr1x),
    .proj_y_o (pr1y)
  );

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pr0x_q <= pr0x;
      pr0y_q <= pr0y;
      pr1x_q <= pr1x;
      pr1y_q <= pr1y;
    end
  end

  // Stage seven: the crossing wins when it lies within the threshold of the point;
  // otherwise the nearer line is kept, the previous one when parallel, else the point itself.
  always_comb begin
    dist2 = $unsigned(SSW'(xr.ex) * SSW'(xr.ex)) + $unsigned(SSW'(xr.ey) * SSW'(xr.ey));
    hit   = xr.v0 && xr.v1 && !xr.par && xr.near && (dist2 < SSW'(SNAP_T2));
    keep0 = xr.v0 && !(xr.v1 && !xr.par && xr.drop0);
    if (hit) begin
      snap_x_d = ix;
      snap_y_d = iy;
    end else if (keep0) begin
      snap_x_d = pr0x_q;
      snap_y_d = pr0y_q;
    end else if (xr.v1) begin
      snap_x_d = pr1x_q;
      snap_y_d = pr1y_q;
    end else begin
      snap_x_d = cur_x_q[6];
      snap_y_d = cur_y_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTAGE]) begin
      snap_x_q <= snap_x_d;
      snap_y_q <= snap_y_d;
    end
  end

  assign out_valid_o = v_q[NSTAGE];
  assign snapped_x_o = snap_x_q;
  assign snapped_y_o = snap_y_q;

  // The input stalls only when the whole pipeline is full behind a stalled output.
  `LSS_ASSERT_IMP(a_stall_from_out, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `LSS_ASSERT_IMP(a_free_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  // A delivered result with nothing behind it leaves the output register empty.
  `LSS_ASSERT_NXT(a_drain, clk_i, rst_ni, out_valid_o && !out_stall_i && !v_q[6], !out_valid_o)

endmodule
